// ===== hw/rtl/tswp_pkg.sv =====
`default_nettype none
package tswp_pkg;

   // defaults of the top level parameters
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MATERIALS_DEF   = 4;

   localparam int NUM_MAT    = 4;
   localparam int RECIP_BITS = 16;
   localparam int PRIO_BITS  = 3;

   // Q1.16 fixed point for t, smoothstep and falloffs
   localparam logic [16:0] Q16_ONE   = 17'h10000;
   localparam logic [17:0] Q16_THREE = 18'd196608;

   // priority boost (10 + p) / 10, the divide as a reciprocal multiply
   localparam logic [4:0]  PRIO_BASE   = 5'd10;
   localparam logic [23:0] DIV10_MUL   = 24'd13421773;
   localparam int          DIV10_SHIFT = 27;

   localparam int W_BITS     = 17;
   localparam int TOTAL_BITS = 19;
   localparam int NUM_BITS   = 25;
   localparam logic [TOTAL_BITS-1:0] SUM_MIN = 19'd7;
   localparam logic [7:0] BYTE_MAX = 8'd255;

   // register kind, paddr bit 3
   localparam logic REG_HEIGHT = 1'b0;
   localparam logic REG_SLOPE  = 1'b1;

   localparam int LANE_LAT = 9;
   localparam int NORM_LAT = 9;

   function automatic int tswp_latency(input int sb);
      return 3 + (sb + 1) + LANE_LAT + 1 + NORM_LAT + 1;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tswp_material.sv =====
`default_nettype none
module tswp_material #(
   parameter int SAMPLE_BITS = tswp_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic [SAMPLE_BITS-1:0]              height,
   input  wire logic [SAMPLE_BITS-1:0]              slope,
   input  wire logic [SAMPLE_BITS-1:0]              h_lo,
   input  wire logic [SAMPLE_BITS-1:0]              h_hi,
   input  wire logic [SAMPLE_BITS-1:0]              s_lo,
   input  wire logic [SAMPLE_BITS-1:0]              s_hi,
   input  wire logic [tswp_pkg::RECIP_BITS-1:0]     recip,
   input  wire logic [tswp_pkg::PRIO_BITS-1:0]      prio,
   input  wire logic                                enable,
   output logic      [tswp_pkg::W_BITS-1:0]         weight
);
   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + tswp_pkg::RECIP_BITS;
   localparam int HSH = SB - 8;
   localparam int SSH = SB - 7;

   // carried controls, one entry per stage
   logic [tswp_pkg::PRIO_BITS-1:0] prio_ff [1:6];
   logic [tswp_pkg::PRIO_BITS-1:0] prio_in [1:6];
   logic en_ff [1:8];
   logic en_in [1:8];
   logic hin_ff [1:4];
   logic hin_in [1:4];
   logic sin_ff [1:4];
   logic sin_in [1:4];

   logic [SB-1:0] hd_ff, hd_in, sd_ff, sd_in;
   logic [tswp_pkg::RECIP_BITS-1:0] recip_ff, recip_in;
   logic [PW-1:0] hp_ff, hp_in, sp_ff, sp_in;
   logic [16:0] ht_ff, ht_in, st_ff, st_in;
   logic [16:0] ht2_ff, ht2_in, st2_ff, st2_in;
   logic [17:0] hk_ff, hk_in, sk_ff, sk_in;
   logic [16:0] hf_ff, hf_in, sf_ff, sf_in;
   logic [16:0] hs_ff, hs_in;
   logic [20:0] x_ff, x_in;
   logic [44:0] y_ff, y_in;
   logic [tswp_pkg::W_BITS-1:0] w_ff, w_in;

   logic [PW-1:0] hsh, ssh;
   logic [33:0] ht2_full, st2_full, hs_full;
   logic [34:0] hsm, ssm;
   logic [21:0] x_full;

   always_comb begin
      // distance outside the window, min test first
      hin_in[1] = !(height < h_lo) && !(height > h_hi);
      hd_in = (height < h_lo) ? h_lo - height : height - h_hi;
      sin_in[1] = !(slope < s_lo) && !(slope > s_hi);
      sd_in = (slope < s_lo) ? s_lo - slope : slope - s_hi;
      recip_in = recip;
      prio_in[1] = prio;
      en_in[1] = enable;
      for (int i = 2; i <= 6; i++) prio_in[i] = prio_ff[i-1];
      for (int i = 2; i <= 8; i++) en_in[i] = en_ff[i-1];
      for (int i = 2; i <= 4; i++) begin
         hin_in[i] = hin_ff[i-1];
         sin_in[i] = sin_ff[i-1];
      end

      hp_in = PW'(hd_ff) * PW'(recip_ff);
      sp_in = PW'(sd_ff) * PW'(recip_ff);

      // t clamped to 1.0, slope uses half the reciprocal
      hsh = hp_ff >> HSH;
      ssh = sp_ff >> SSH;
      ht_in = (hsh > PW'(tswp_pkg::Q16_ONE)) ? tswp_pkg::Q16_ONE : hsh[16:0];
      st_in = (ssh > PW'(tswp_pkg::Q16_ONE)) ? tswp_pkg::Q16_ONE : ssh[16:0];

      ht2_full = 34'(ht_ff) * 34'(ht_ff);
      st2_full = 34'(st_ff) * 34'(st_ff);
      ht2_in = ht2_full[32:16];
      st2_in = st2_full[32:16];
      hk_in = tswp_pkg::Q16_THREE - {ht_ff, 1'b0};
      sk_in = tswp_pkg::Q16_THREE - {st_ff, 1'b0};

      hsm = 35'(ht2_ff) * 35'(hk_ff);
      ssm = 35'(st2_ff) * 35'(sk_ff);
      hf_in = hin_ff[4] ? tswp_pkg::Q16_ONE : tswp_pkg::Q16_ONE - hsm[32:16];
      sf_in = sin_ff[4] ? tswp_pkg::Q16_ONE : tswp_pkg::Q16_ONE - ssm[32:16];

      hs_full = 34'(hf_ff) * 34'(sf_ff);
      hs_in = hs_full[32:16];

      x_full = 22'(hs_ff) * 22'(tswp_pkg::PRIO_BASE + 5'(prio_ff[6]));
      x_in = x_full[20:0];

      y_in = 45'(x_ff) * 45'(tswp_pkg::DIV10_MUL);

      w_in = en_ff[8] ? y_ff[tswp_pkg::DIV10_SHIFT +: tswp_pkg::W_BITS] : '0;
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= 6; i++) prio_ff[i] <= prio_in[i];
      for (int i = 1; i <= 8; i++) en_ff[i] <= en_in[i];
      for (int i = 1; i <= 4; i++) begin
         hin_ff[i] <= hin_in[i];
         sin_ff[i] <= sin_in[i];
      end
      hd_ff    <= hd_in;
      sd_ff    <= sd_in;
      recip_ff <= recip_in;
      hp_ff    <= hp_in;
      sp_ff    <= sp_in;
      ht_ff    <= ht_in;
      st_ff    <= st_in;
      ht2_ff   <= ht2_in;
      st2_ff   <= st2_in;
      hk_ff    <= hk_in;
      sk_ff    <= sk_in;
      hf_ff    <= hf_in;
      sf_ff    <= sf_in;
      hs_ff    <= hs_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
   end

   assign weight = w_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tswp_norm.sv =====
`default_nettype none
module tswp_norm (
   input  wire logic                                clock,
   input  wire logic [tswp_pkg::W_BITS-1:0]         weight,
   input  wire logic [tswp_pkg::TOTAL_BITS-1:0]     total,
   output logic      [7:0]                          byte_out
);
   localparam int NB = tswp_pkg::NUM_BITS;
   localparam int DB = tswp_pkg::TOTAL_BITS + 7;

   logic [NB-1:0] rem_ff [0:8];
   logic [NB-1:0] rem_in [0:8];
   logic [tswp_pkg::TOTAL_BITS-1:0] den_ff [0:7];
   logic [tswp_pkg::TOTAL_BITS-1:0] den_in [0:7];
   logic [7:0] q_ff [0:8];
   logic [7:0] q_in [0:8];
   logic small_ff [0:8];
   logic small_in [0:8];
   logic [7:0] sbyte_ff [0:8];
   logic [7:0] sbyte_in [0:8];

   logic [NB-1:0] num;
   logic [DB-1:0] dsh;

   always_comb begin
      // weight * 255 as a shift and subtract
      num = ({weight, 8'd0}) - NB'(weight);
      rem_in[0]   = num;
      den_in[0]   = total;
      q_in[0]     = '0;
      small_in[0] = total < tswp_pkg::SUM_MIN;
      sbyte_in[0] = (num[NB-1:16] > 9'(tswp_pkg::BYTE_MAX)) ?
                    tswp_pkg::BYTE_MAX : num[23:16];
      dsh = '0;
      // restoring divide, one quotient bit a stage, msb first
      for (int s = 1; s <= 8; s++) begin
         dsh = DB'(den_ff[s-1]) << (8 - s);
         if (DB'(rem_ff[s-1]) >= dsh) begin
            rem_in[s] = rem_ff[s-1] - NB'(dsh);
            q_in[s]   = q_ff[s-1] | (8'd1 << (8 - s));
         end else begin
            rem_in[s] = rem_ff[s-1];
            q_in[s]   = q_ff[s-1];
         end
         small_in[s] = small_ff[s-1];
         sbyte_in[s] = sbyte_ff[s-1];
         if (s < 8) den_in[s] = den_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= 8; s++) begin
         rem_ff[s]   <= rem_in[s];
         q_ff[s]     <= q_in[s];
         small_ff[s] <= small_in[s];
         sbyte_ff[s] <= sbyte_in[s];
      end
      for (int s = 0; s <= 7; s++) den_ff[s] <= den_in[s];
   end

   assign byte_out = small_ff[8] ? sbyte_ff[8] : q_ff[8];

endmodule
`default_nettype wire

// ===== hw/rtl/terrain_splat_weight_pixel_unit.sv =====
`default_nettype none
// Splat-map weights for one height-map pixel per clock. Pulse start with the centre height,
// its four neighbours and the edge flags; busy never rises, so a pixel can be issued on
// every cycle. Each pixel gives exactly one transaction on rsp_strobe, a fixed
// tswp_latency(SAMPLE_BITS) cycles later (40 at 16-bit samples), in issue order, held for
// one cycle only: the receiver cannot stall, so it must take every result as it comes.
// The latency is set by the three gradient stages, the square root for the slope (one root
// bit per stage, SAMPLE_BITS+1 stages), the nine-stage falloff lane per material, the sum
// register, the nine-stage normalising divide and the result register. Material windows
// are written through the APB port at byte address 8*i (height window even, slope window
// odd); write them only while no pixel is in flight.
module terrain_splat_weight_pixel_unit #(
   parameter int SAMPLE_BITS         = tswp_pkg::SAMPLE_BITS_DEF,
   parameter int MATERIALS_PER_PIXEL = tswp_pkg::MATERIALS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel in
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [SAMPLE_BITS-1:0] req_center_height,
   input  wire logic [SAMPLE_BITS-1:0] req_left_height,
   input  wire logic [SAMPLE_BITS-1:0] req_right_height,
   input  wire logic [SAMPLE_BITS-1:0] req_up_height,
   input  wire logic [SAMPLE_BITS-1:0] req_down_height,
   input  wire logic                   req_at_left_edge,
   input  wire logic                   req_at_right_edge,
   input  wire logic                   req_at_top_edge,
   input  wire logic                   req_at_bottom_edge,
   // weights out
   output logic                        rsp_strobe,
   output logic [7:0]                  rsp_weight0,
   output logic [7:0]                  rsp_weight1,
   output logic [7:0]                  rsp_weight2,
   output logic [7:0]                  rsp_weight3,
   // configuration
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [5:0]             paddr,
   input  wire logic [63:0]            pwdata,
   output logic      [63:0]            prdata,
   output logic                        pready
);
   localparam int SB  = SAMPLE_BITS;
   localparam int HW  = 2 * SB + tswp_pkg::RECIP_BITS;
   localparam int SWB = 2 * SB + tswp_pkg::PRIO_BITS + 1;
   localparam int SQ  = SB + 1;
   localparam int LAT = tswp_pkg::tswp_latency(SB);
   localparam int NM  = tswp_pkg::NUM_MAT;

   // ---------------------------------------------------------------- configuration
   logic [HW-1:0]  height_win_ff [NM];
   logic [SWB-1:0] slope_win_ff  [NM];
   logic cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NM; m++) begin
            height_win_ff[m] <= '0;
            slope_win_ff[m]  <= '0;
         end
      end else if (cfg_write) begin
         unique case (paddr[3])
            tswp_pkg::REG_HEIGHT: height_win_ff[paddr[5:4]] <= pwdata[HW-1:0];
            tswp_pkg::REG_SLOPE:  slope_win_ff[paddr[5:4]]  <= pwdata[SWB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         tswp_pkg::REG_HEIGHT: prdata = 64'(height_win_ff[paddr[5:4]]);
         tswp_pkg::REG_SLOPE:  prdata = 64'(slope_win_ff[paddr[5:4]]);
         default:              prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- valid chain
   // nothing ever holds the pipe, every stage advances each cycle
   logic [LAT-1:0] valid_ff, valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // ---------------------------------------------------------------- gradient
   // edge neighbours fall back to the centre, then absolute differences
   logic [SB-1:0] lft, rgt, upp, dwn;
   logic [SB-1:0] c0_ff, c0_in, a_ff, a_in, b_ff, b_in;
   logic [SB-1:0] c1_ff, c1_in, c2_ff, c2_in;
   logic [2*SB-1:0] aa_ff, aa_in, bb_ff, bb_in;
   logic [2*SB+1:0] sq_ff, sq_in;

   always_comb begin
      lft = req_at_left_edge   ? req_center_height : req_left_height;
      rgt = req_at_right_edge  ? req_center_height : req_right_height;
      upp = req_at_top_edge    ? req_center_height : req_up_height;
      dwn = req_at_bottom_edge ? req_center_height : req_down_height;
      c0_in = req_center_height;
      a_in  = (rgt >= lft) ? rgt - lft : lft - rgt;
      b_in  = (dwn >= upp) ? dwn - upp : upp - dwn;
      c1_in = c0_ff;
      aa_in = (2*SB)'(a_ff) * (2*SB)'(a_ff);
      bb_in = (2*SB)'(b_ff) * (2*SB)'(b_ff);
      c2_in = c1_ff;
      sq_in = (2*SB+2)'(aa_ff) + (2*SB+2)'(bb_ff);
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
      c1_ff <= c1_in;
      aa_ff <= aa_in;
      bb_ff <= bb_in;
      c2_ff <= c2_in;
      sq_ff <= sq_in;
   end

   // ---------------------------------------------------------------- square root
   // digit-by-digit root, two radicand bits per stage
   logic [SB:0]     root_ff [SQ];
   logic [SB:0]     root_in [SQ];
   logic [SB+1:0]   rem_ff  [SQ];
   logic [SB+1:0]   rem_in  [SQ];
   logic [2*SB+1:0] rad_ff  [SQ];
   logic [2*SB+1:0] rad_in  [SQ];
   logic [SB-1:0]   cs_ff   [SQ];
   logic [SB-1:0]   cs_in   [SQ];

   always_comb begin
      logic [SB:0]     pr_root;
      logic [SB+1:0]   pr_rem;
      logic [2*SB+1:0] pr_rad;
      logic [SB+3:0]   cur, trial;
      for (int j = 0; j < SQ; j++) begin
         if (j == 0) begin
            pr_root = '0;
            pr_rem  = '0;
            pr_rad  = sq_ff;
            cs_in[j] = c2_ff;
         end else begin
            pr_root = root_ff[j-1];
            pr_rem  = rem_ff[j-1];
            pr_rad  = rad_ff[j-1];
            cs_in[j] = cs_ff[j-1];
         end
         cur   = {pr_rem, pr_rad[2*SB+1:2*SB]};
         trial = {1'b0, pr_root, 2'b01};
         if (cur >= trial) begin
            rem_in[j]  = (SB+2)'(cur - trial);
            root_in[j] = {pr_root[SB-1:0], 1'b1};
         end else begin
            rem_in[j]  = cur[SB+1:0];
            root_in[j] = {pr_root[SB-1:0], 1'b0};
         end
         rad_in[j] = pr_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < SQ; j++) begin
         root_ff[j] <= root_in[j];
         rem_ff[j]  <= rem_in[j];
         rad_ff[j]  <= rad_in[j];
         cs_ff[j]   <= cs_in[j];
      end
   end

   // slope is half the root
   logic [SB-1:0] slope;
   assign slope = root_ff[SQ-1][SB:1];

   // ---------------------------------------------------------------- material lanes
   logic [tswp_pkg::W_BITS-1:0] lane_w [NM];

   for (genvar m = 0; m < NM; m++) begin : g_lane
      logic lane_en;
      // materials past the configured count weigh nothing
      assign lane_en = (m < MATERIALS_PER_PIXEL) && slope_win_ff[m][2*SB+tswp_pkg::PRIO_BITS];
      tswp_material #(.SAMPLE_BITS(SB)) u_mat (
         .clock  (clock),
         .height (cs_ff[SQ-1]),
         .slope  (slope),
         .h_lo   (height_win_ff[m][SB-1:0]),
         .h_hi   (height_win_ff[m][2*SB-1:SB]),
         .s_lo   (slope_win_ff[m][SB-1:0]),
         .s_hi   (slope_win_ff[m][2*SB-1:SB]),
         .recip  (height_win_ff[m][2*SB +: tswp_pkg::RECIP_BITS]),
         .prio   (slope_win_ff[m][2*SB +: tswp_pkg::PRIO_BITS]),
         .enable (lane_en),
         .weight (lane_w[m])
      );
   end

   // ---------------------------------------------------------------- sum and normalise
   logic [tswp_pkg::W_BITS-1:0]     w_ff [NM];
   logic [tswp_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic [7:0] nbyte [NM];

   always_comb begin
      total_in = '0;
      for (int m = 0; m < NM; m++) total_in = total_in + tswp_pkg::TOTAL_BITS'(lane_w[m]);
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < NM; m++) w_ff[m] <= lane_w[m];
      total_ff <= total_in;
   end

   for (genvar m = 0; m < NM; m++) begin : g_norm
      tswp_norm u_norm (
         .clock    (clock),
         .weight   (w_ff[m]),
         .total    (total_ff),
         .byte_out (nbyte[m])
      );
   end

   // ---------------------------------------------------------------- result register
   logic [7:0] out_ff [NM];

   always_ff @(posedge clock) begin
      for (int m = 0; m < NM; m++) out_ff[m] <= nbyte[m];
   end

   assign rsp_strobe  = valid_ff[LAT-1];
   assign rsp_weight0 = out_ff[0];
   assign rsp_weight1 = out_ff[1];
   assign rsp_weight2 = out_ff[2];
   assign rsp_weight3 = out_ff[3];

endmodule
`default_nettype wire

// ===== hw/rtl/tswp_checker.sv =====
`default_nettype none
module tswp_checker #(
   parameter int SAMPLE_BITS = tswp_pkg::SAMPLE_BITS_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [7:0] rsp_weight0,
   input wire logic [7:0] rsp_weight1,
   input wire logic [7:0] rsp_weight2,
   input wire logic [7:0] rsp_weight3,
   input wire logic       pready
);
   localparam int LAT = tswp_pkg::tswp_latency(SAMPLE_BITS);
   localparam int CW  = $clog2(LAT + 1);

   // cycles since reset, saturating at the latency
   logic [CW-1:0] age_ff, age_in;
   logic settled;

   assign settled = (age_ff == CW'(LAT));
   assign age_in  = settled ? age_ff : age_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) age_ff <= '0;
      else       age_ff <= age_in;
   end

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      settled |-> (rsp_strobe == $past(start, LAT)))
      else $error("result strobe out of step with issued pixels");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (10'(rsp_weight0) + 10'(rsp_weight1) + 10'(rsp_weight2)
                      + 10'(rsp_weight3) <= 10'd255))
      else $error("weights sum past full scale");

endmodule

bind terrain_splat_weight_pixel_unit tswp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tswp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_weight0 (rsp_weight0),
   .rsp_weight1 (rsp_weight1),
   .rsp_weight2 (rsp_weight2),
   .rsp_weight3 (rsp_weight3),
   .pready      (pready)
);
`default_nettype wire

// ===== bench/tswp_weight_checker.sv =====
`default_nettype none
module tswp_weight_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [15:0] req_center_height,
   input  wire logic [15:0] req_left_height,
   input  wire logic [15:0] req_right_height,
   input  wire logic [15:0] req_up_height,
   input  wire logic [15:0] req_down_height,
   input  wire logic        req_at_left_edge,
   input  wire logic        req_at_right_edge,
   input  wire logic        req_at_top_edge,
   input  wire logic        req_at_bottom_edge,
   input  wire logic        rsp_strobe,
   input  wire logic [7:0]  rsp_weight0,
   input  wire logic [7:0]  rsp_weight1,
   input  wire logic [7:0]  rsp_weight2,
   input  wire logic [7:0]  rsp_weight3,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               pending,
   output int               weights_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] height_win [4];
   logic [63:0] slope_win  [4];
   logic [31:0] weight_q [$];

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // 1 - smoothstep of distance times reciprocal, q1.16
   function automatic longint unsigned edge_falloff(input longint unsigned v,
         input longint unsigned lo, input longint unsigned hi,
         input longint unsigned recip, input int extra);
      longint unsigned gap, t, t2;
      if (v < lo) gap = lo - v;
      else if (v > hi) gap = v - hi;
      else return 65536;
      t = (gap * recip) >> (8 + extra);
      if (t > 65536) t = 65536;
      t2 = (t * t) >> 16;
      return 65536 - ((t2 * (196608 - 2 * t)) >> 16);
   endfunction

   function automatic logic [31:0] splat_weights(input logic [15:0] c, l, r, u, d,
         input logic el, er, et, eb);
      longint unsigned a, b, slope, total, hf, sf;
      longint unsigned w [4];
      logic [31:0] bytes;
      if (el) l = c;
      if (er) r = c;
      if (et) u = c;
      if (eb) d = c;
      a = (r >= l) ? r - l : l - r;
      b = (d >= u) ? d - u : u - d;
      slope = root_floor(a * a + b * b) >> 1;
      total = 0;
      for (int m = 0; m < 4; m++) begin
         if (!slope_win[m][35]) w[m] = 0;
         else begin
            hf = edge_falloff(c, height_win[m][15:0], height_win[m][31:16],
                              height_win[m][47:32], 0);
            sf = edge_falloff(slope, slope_win[m][15:0], slope_win[m][31:16],
                              height_win[m][47:32], 1);
            w[m] = (((hf * sf) >> 16) * (10 + slope_win[m][34:32])) / 10;
         end
         total += w[m];
      end
      for (int m = 0; m < 4; m++) begin
         longint unsigned v;
         if (total >= 7) v = (w[m] * 255) / total;
         else begin
            v = (w[m] * 255) >> 16;
            if (v > 255) v = 255;
         end
         bytes[8*m +: 8] = v[7:0];
      end
      return bytes;
   endfunction

   always @(posedge clock) begin
      logic [31:0] want, got;
      if (reset) begin
         for (int m = 0; m < 4; m++) begin
            height_win[m] <= '0;
            slope_win[m]  <= '0;
         end
         fail_count   <= 0;
         weights_seen <= 0;
         weight_q.delete();
         pending      <= 0;
      end else begin
         // register write transaction
         if (psel && penable && pwrite && pready) begin
            if (paddr[3]) slope_win[paddr[5:4]]  <= pwdata;
            else          height_win[paddr[5:4]] <= pwdata;
         end
         if (start && !busy)
            weight_q.push_back(splat_weights(req_center_height, req_left_height,
               req_right_height, req_up_height, req_down_height, req_at_left_edge,
               req_at_right_edge, req_at_top_edge, req_at_bottom_edge));
         if (rsp_strobe) begin
            got = {rsp_weight3, rsp_weight2, rsp_weight1, rsp_weight0};
            weights_seen <= weights_seen + 1;
            if (weight_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected weights %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = weight_q.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("weight mismatch: expected %h got %h (w3..w0)", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= weight_q.size();
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb_terrain_splat_weight_pixel_unit.sv =====
`default_nettype none
module tb_terrain_splat_weight_pixel_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] c_h = '0, l_h = '0, r_h = '0, u_h = '0, d_h = '0;
   logic el = 1'b0, er = 1'b0, et = 1'b0, eb = 1'b0;
   logic rsp_strobe;
   logic [7:0] w0, w1, w2, w3;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [5:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;
   int fail_count, pending, weights_seen;
   int cycles = 0;
   int pixels = 0;
   int settings = 0;
   localparam int CYCLE_LIMIT = 400000;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   terrain_splat_weight_pixel_unit u_dut (
      .clock, .reset, .start, .busy,
      .req_center_height(c_h), .req_left_height(l_h), .req_right_height(r_h),
      .req_up_height(u_h), .req_down_height(d_h),
      .req_at_left_edge(el), .req_at_right_edge(er),
      .req_at_top_edge(et), .req_at_bottom_edge(eb),
      .rsp_strobe, .rsp_weight0(w0), .rsp_weight1(w1), .rsp_weight2(w2),
      .rsp_weight3(w3), .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   tswp_weight_checker u_check (
      .clock, .reset, .start, .busy,
      .req_center_height(c_h), .req_left_height(l_h), .req_right_height(r_h),
      .req_up_height(u_h), .req_down_height(d_h),
      .req_at_left_edge(el), .req_at_right_edge(er),
      .req_at_top_edge(et), .req_at_bottom_edge(eb),
      .rsp_strobe, .rsp_weight0(w0), .rsp_weight1(w1), .rsp_weight2(w2),
      .rsp_weight3(w3), .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending, .weights_seen
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d weight sets outstanding", pending);
         $display("tb_terrain_splat_weight_pixel_unit: done, errors");
         $finish;
      end
   end

   // apb write: setup then access, pready is tied high; psel stays up between writes
   task automatic csr_write(input int idx, input logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 6'(idx * 8);
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
   endtask

   // wait for the pipe to empty, then the full latency as margin
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (tswp_pkg::tswp_latency(tswp_pkg::SAMPLE_BITS_DEF) + 4) @(negedge clock);
   endtask

   function automatic logic [63:0] rand_height_win(input int mode);
      logic [15:0] lo, hi, rc;
      lo = 16'($urandom);
      hi = 16'($urandom);
      rc = 16'($urandom_range(0, 2048));
      if (mode == 0) begin
         lo = 16'h0000; hi = 16'hffff; rc = 16'hffff;
      end else if (mode == 1) begin
         lo = 16'hffff; hi = 16'h0000; rc = 16'($urandom);
      end else if (mode == 2) rc = 16'h0000;
      else if (mode == 3 && lo > hi) {lo, hi} = {hi, lo};
      return {16'($urandom), rc, hi, lo};
   endfunction

   function automatic logic [63:0] rand_slope_win(input int mode);
      logic [15:0] lo, hi;
      logic [2:0] pr;
      lo = 16'($urandom_range(0, 8000));
      hi = lo + 16'($urandom_range(0, 16000));
      pr = 3'($urandom);
      if (mode == 0) begin
         lo = 16'h0000; hi = 16'hffff; pr = 3'd7;
      end else if (mode == 1) begin
         lo = 16'hffff; hi = 16'h0000; pr = 3'd0;
      end
      return {28'($urandom), ($urandom_range(0, 3) != 0), pr, hi, lo};
   endfunction

   task automatic configure(input int mode);
      for (int m = 0; m < 4; m++) begin
         csr_write(2 * m, rand_height_win(mode));
         csr_write(2 * m + 1, rand_slope_win(mode));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings++;
   endtask

   // issue one pixel, waiting for busy to be low at the edge
   task automatic send_pixel(input logic [15:0] c, l, r, u, d, input logic [3:0] edges);
      c_h <= c; l_h <= l; r_h <= r; u_h <= u; d_h <= d;
      {el, er, et, eb} <= edges;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      pixels++;
   endtask

   task automatic random_pixel(input bit allow_gaps);
      logic [15:0] c;
      logic [3:0] edges;
      int spread;
      c = 16'($urandom);
      spread = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(1, 4000);
      edges = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'b0000;
      send_pixel(c, 16'(c + $urandom_range(0, spread)), 16'(c - $urandom_range(0, spread)),
                 16'($urandom_range(0, 65535)) & (spread == 65535 ? 16'hffff : 16'h0fff)
                 ^ (spread == 65535 ? 16'h0 : c), 16'(c + $urandom_range(0, spread)),
                 edges);
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state: every material disabled, weights must be zero
      send_pixel(16'h8000, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0000);
      start <= 1'b0;
      drain();

      // widest windows, full priority
      configure(0);
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b0000);
      send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'b1111);
      send_pixel(16'h8000, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0000);
      send_pixel(16'h8000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 4'b0000);
      send_pixel(16'h1234, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b1000);
      send_pixel(16'h1234, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0100);
      send_pixel(16'h1234, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0010);
      send_pixel(16'h1234, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0001);
      start <= 1'b0;
      drain();

      // minimum above maximum, then zero reciprocal
      configure(1);
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b0000);
      send_pixel(16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 4'b0000);
      send_pixel(16'h7fff, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 4'b0000);
      start <= 1'b0;
      drain();
      configure(2);
      send_pixel(16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 4'b0000);
      send_pixel(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 4'b0000);
      send_pixel(16'h4000, 16'h3000, 16'h5000, 16'h3800, 16'h4800, 4'b0000);
      start <= 1'b0;
      drain();

      // random phases with fresh windows, gaps except in the last ones
      for (int ph = 0; ph < 12; ph++) begin
         configure(ph < 2 ? ph : 3);
         for (int k = 0; k < 155; k++) random_pixel(ph < 10);
         start <= 1'b0;
         drain();
      end

      $display("covered %0d pixels over %0d window settings, %0d weight sets checked",
               pixels, settings, weights_seen);
      if (fail_count == 0) begin
         $display("tb_terrain_splat_weight_pixel_unit: done, clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb_terrain_splat_weight_pixel_unit: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
